[hw/rtl/wsm_pkg.sv]
// shared constants and types for the wind sensor median / moving-average / calibration block
// used by the stream interfaces, the controller, the datapath and the top level
package wsm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS       = 16;

    localparam int ALPHA_BITS  = 16;
    localparam int SLOPE_BITS  = 16;
    localparam int OFFSET_BITS = 24;
    localparam int SPEED_BITS  = 24;

    localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = 16'd6554;
    localparam logic [SLOPE_BITS-1:0]  SLOPE_RESET  = 16'd1059;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 24'd273285;
    localparam logic [SPEED_BITS-1:0]  SPEED_MAX    = 24'hFFFFFF;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_SLOPE  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    typedef struct packed {
        logic [ALPHA_BITS-1:0]  alpha;
        logic [SLOPE_BITS-1:0]  slope;
        logic [OFFSET_BITS-1:0] offset;
    } t_cfg;

    typedef struct packed {
        logic win_wr;   // store the accepted word into the window
        logic med_ld;   // take the median, load or prepare the average
        logic mul_ema;  // alpha * (median - average)
        logic acc_upd;  // fold the product into the average
        logic mul_cal;  // slope * filtered
        logic out_ld;   // add intercept, saturate, load the output stage
    } t_dp_cmd;

    typedef struct packed {
        logic started;
        logic out_free;
    } t_dp_stat;

endpackage

[hw/rtl/wsm_if.sv]
// valid/ready stream interfaces for the sample input and the result output
// depends on wsm_pkg for default widths
interface wsm_in_if #(
    parameter int SAMPLE_BITS = wsm_pkg::SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wsm_out_if #(
    parameter int SAMPLE_BITS = wsm_pkg::SAMPLE_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic [SAMPLE_BITS-1:0]           filtered;
    logic [wsm_pkg::SPEED_BITS-1:0]   speed;

    modport source (output valid, output filtered, output speed, input ready);
    modport sink   (input valid, input filtered, input speed, output ready);
endinterface

[hw/rtl/wsm_ctrl.sv]
// sequencer for one word: window write, median, average update, calibration, output
// depends on wsm_pkg for the command and status structs
module wsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wsm_pkg::t_dp_stat i_stat,
    output wsm_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MED  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.win_wr = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MED;
                end
            end
            S_MED: begin
                o_cmd.med_ld = 1'b1;
                // the first word loads the average directly
                n_state = i_stat.started ? S_MUL1 : S_MUL2;
            end
            S_MUL1: begin
                o_cmd.mul_ema = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.acc_upd = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_cal = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/wsm_datapath.sv]
// window, median, moving average and calibration datapath with one shared multiplier
// depends on wsm_pkg; driven by wsm_ctrl through t_dp_cmd
module wsm_datapath #(
    parameter int SAMPLE_BITS = wsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wsm_pkg::t_cfg                  i_cfg,
    input  wsm_pkg::t_dp_cmd               i_cmd,
    output wsm_pkg::t_dp_stat              o_stat,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [SAMPLE_BITS-1:0]         o_filtered,
    output logic [wsm_pkg::SPEED_BITS-1:0] o_speed
);

    localparam int FB = wsm_pkg::FRAC_BITS;
    localparam int AW = SAMPLE_BITS + FB;          // average, unsigned Q.16
    localparam int DW = AW + 1;                    // signed difference
    localparam int MA = wsm_pkg::ALPHA_BITS + 1;   // signed multiplier a operand
    localparam int PW = MA + DW;                   // product
    localparam int CW = wsm_pkg::SLOPE_BITS + SAMPLE_BITS + 1;  // calibration sum

    logic [SAMPLE_BITS-1:0] r_win [3];
    logic [1:0]             r_slot;
    logic [AW-1:0]          r_acc;
    logic                   r_started;
    logic signed [DW-1:0]   r_diff;
    logic signed [PW-1:0]   r_prod;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_filtered;
    logic [wsm_pkg::SPEED_BITS-1:0] r_speed;

    logic [SAMPLE_BITS-1:0] lo_ab;
    logic [SAMPLE_BITS-1:0] hi_ab;
    logic [SAMPLE_BITS-1:0] hi_c;
    logic [SAMPLE_BITS-1:0] med;
    logic [SAMPLE_BITS-1:0] filt;
    logic signed [DW-1:0]   diff;
    logic signed [MA-1:0]   mul_a;
    logic signed [DW-1:0]   mul_b;
    logic signed [PW-1:0]   acc_sum;
    logic [CW-1:0]          cal_sum;
    logic [wsm_pkg::SPEED_BITS-1:0] speed;
    logic [1:0]             wr_slot;

    // median of three as max(min(a,b), min(max(a,b),c))
    always_comb begin
        lo_ab = (r_win[0] <= r_win[1]) ? r_win[0] : r_win[1];
        hi_ab = (r_win[0] <= r_win[1]) ? r_win[1] : r_win[0];
        hi_c  = (hi_ab <= r_win[2]) ? hi_ab : r_win[2];
        med   = (lo_ab >= hi_c) ? lo_ab : hi_c;
    end

    assign filt    = r_acc[AW-1:FB];
    assign diff    = $signed({1'b0, med, {FB{1'b0}}}) - $signed({1'b0, r_acc});
    assign wr_slot = (r_slot == 2'd3) ? 2'd0 : r_slot;

    // shared multiplier operands
    always_comb begin
        if (i_cmd.mul_cal) begin
            mul_a = $signed({1'b0, i_cfg.slope});
            mul_b = $signed({{(DW - SAMPLE_BITS){1'b0}}, filt});
        end else begin
            mul_a = $signed({1'b0, i_cfg.alpha});
            mul_b = r_diff;
        end
    end

    // floor division of the signed product equals the truncated blend
    assign acc_sum = $signed({{(PW - AW){1'b0}}, r_acc}) + (r_prod >>> FB);

    always_comb begin
        cal_sum = {1'b0, r_prod[CW-2:0]} + CW'(i_cfg.offset);
        if (filt == '0) begin
            speed = '0;
        end else if (cal_sum > CW'(wsm_pkg::SPEED_MAX)) begin
            speed = wsm_pkg::SPEED_MAX;
        end else begin
            speed = cal_sum[wsm_pkg::SPEED_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0]  <= '0;
            r_win[1]  <= '0;
            r_win[2]  <= '0;
            r_slot    <= 2'd0;
            r_acc     <= '0;
            r_started <= 1'b0;
        end else begin
            if (i_cmd.win_wr) begin
                r_win[wr_slot] <= i_sample;
                r_slot         <= (wr_slot == 2'd2) ? 2'd0 : wr_slot + 2'd1;
            end
            if (i_cmd.med_ld && !r_started) begin
                r_acc     <= {med, {FB{1'b0}}};
                r_started <= 1'b1;
            end
            if (i_cmd.acc_upd) begin
                r_acc <= acc_sum[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.med_ld) begin
            r_diff <= diff;
        end
        if (i_cmd.mul_ema || i_cmd.mul_cal) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.out_ld) begin
            r_filtered <= filt;
            r_speed    <= speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.started  = r_started;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_filtered;
    assign o_speed         = r_speed;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("window slot out of range");

    a_upd_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_upd |-> r_started)
        else $error("average update before first load");

    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_filtered == '0) |-> (r_speed == '0))
        else $error("speed not zero for zero reading");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> (!r_out_valid || i_out_ready))
        else $error("output stage overwritten while full");

endmodule

[hw/rtl/wind_sensor_median_ema_calibrate.sv]
// top level of the wind sensor filter: register port, controller and datapath
// depends on wsm_pkg, wsm_if, wsm_ctrl and wsm_datapath
//
// Usage:
//   i_in carries one converter sample per word (valid/ready, accepted when
//   both are high). o_out carries one result word per sample: the filtered
//   reading and the calibrated speed in km/h, unsigned Q8.16.
//   The APB port holds alpha (0x0), slope (0x4) and intercept (0x8); write
//   them only while no sample is in flight. pready is tied high.
// Sequence:
//   a sample passes the median, average multiply, average update and
//   calibration steps, then its result loads into the output register;
//   the first sample skips both average steps and loads the average
//   directly. The multiplier is used twice per sample (once for the first)
//   and the sequencer takes the next sample only after that load.
// Reset:
//   synchronous, active low; clears the window, the average and the output
//   valid flag and restores the register defaults.
// Stall:
//   a result waits in the output register while o_out.ready is low; the
//   sequencer holds its last step until that register frees, and i_in.ready
//   stays low meanwhile.
module wind_sensor_median_ema_calibrate #(
    parameter int SAMPLE_BITS = wsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wsm_in_if.sink                             i_in,
    wsm_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wsm_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [wsm_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [wsm_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready
);

    wsm_pkg::t_cfg     r_cfg;
    wsm_pkg::t_dp_cmd  cmd;
    wsm_pkg::t_dp_stat stat;
    logic              apb_wr;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha  <= wsm_pkg::ALPHA_RESET;
            r_cfg.slope  <= wsm_pkg::SLOPE_RESET;
            r_cfg.offset <= wsm_pkg::OFFSET_RESET;
        end else if (apb_wr) begin
            unique case (reg_idx)
                wsm_pkg::REG_ALPHA:  r_cfg.alpha  <= pwdata[wsm_pkg::ALPHA_BITS-1:0];
                wsm_pkg::REG_SLOPE:  r_cfg.slope  <= pwdata[wsm_pkg::SLOPE_BITS-1:0];
                wsm_pkg::REG_OFFSET: r_cfg.offset <= pwdata[wsm_pkg::OFFSET_BITS-1:0];
                default: begin
                    // address beyond the register list: ignored
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wsm_pkg::REG_ALPHA:  prdata = wsm_pkg::PDATA_BITS'(r_cfg.alpha);
            wsm_pkg::REG_SLOPE:  prdata = wsm_pkg::PDATA_BITS'(r_cfg.slope);
            wsm_pkg::REG_OFFSET: prdata = wsm_pkg::PDATA_BITS'(r_cfg.offset);
            default:             prdata = '0;
        endcase
    end

    wsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wsm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_in.sample),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_filtered  (o_out.filtered),
        .o_speed     (o_out.speed)
    );

endmodule

[test/wsm_result_checker.sv]
`timescale 1ns / 100ps
// result checker for the wind sensor filter: follows register writes, predicts every result word
// depends on wsm_pkg and the stream interfaces of wsm_if
module wsm_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wsm_in_if                                  in_ch,
    wsm_out_if                                 out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wsm_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [wsm_pkg::PDATA_BITS-1:0]     pwdata,
    input  logic                               pready,
    output int                                 o_pending,
    output int                                 o_fail_count
);
    import wsm_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;

    typedef struct packed {
        logic [SB-1:0]         filtered;
        logic [SPEED_BITS-1:0] speed;
    } t_reading;

    logic [ALPHA_BITS-1:0]    alpha_q;
    logic [SLOPE_BITS-1:0]    slope_q;
    logic [OFFSET_BITS-1:0]   offset_q;
    logic [SB-1:0]            window_q [3];
    logic [1:0]               slot_q;
    logic [SB+FRAC_BITS-1:0]  avg_q;
    logic                     avg_started_q;
    t_reading                 readings_due [$];

    function automatic logic [SB-1:0] median3(input logic [SB-1:0] a, b, c);
        logic [SB-1:0] lo;
        logic [SB-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        // c below the upper of the pair: median is the larger of c and the lower
        return (c < hi) ? ((c > lo) ? c : lo) : hi;
    endfunction

    task automatic predict_reading(input logic [SB-1:0] x, output t_reading r);
        logic [SB-1:0] med;
        logic [SB-1:0] filt;
        logic [63:0]   mix;
        logic [63:0]   spd;
        window_q[slot_q] = x;
        slot_q = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
        med = median3(window_q[0], window_q[1], window_q[2]);
        if (!avg_started_q) begin
            avg_q = {med, {FRAC_BITS{1'b0}}};
            avg_started_q = 1'b1;
        end else begin
            mix = 64'(alpha_q) * 64'({med, {FRAC_BITS{1'b0}}})
                + (64'd65536 - 64'(alpha_q)) * 64'(avg_q);
            avg_q = mix[FRAC_BITS +: SB+FRAC_BITS];
        end
        filt = avg_q[FRAC_BITS +: SB];
        spd = 64'(slope_q) * 64'(filt) + 64'(offset_q);
        if (filt == '0) begin
            spd = '0;
        end else if (spd > 64'(SPEED_MAX)) begin
            spd = 64'(SPEED_MAX);
        end
        r.filtered = filt;
        r.speed    = spd[SPEED_BITS-1:0];
    endtask

    task automatic report_fault(input string what, input longint got, input longint want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            alpha_q       = ALPHA_RESET;
            slope_q       = SLOPE_RESET;
            offset_q      = OFFSET_RESET;
            window_q[0]   = '0;
            window_q[1]   = '0;
            window_q[2]   = '0;
            slot_q        = 2'd0;
            avg_q         = '0;
            avg_started_q = 1'b0;
            readings_due.delete();
        end else begin
            // results first, so a stray word never meets this edge's prediction
            if (out_ch.valid && out_ch.ready) begin
                got.filtered = out_ch.filtered;
                got.speed    = out_ch.speed;
                if (readings_due.size() == 0) begin
                    report_fault("word with nothing due, filtered", got.filtered, 0);
                end else begin
                    want = readings_due.pop_front();
                    if (got.filtered !== want.filtered) begin
                        report_fault("filtered", got.filtered, want.filtered);
                    end
                    if (got.speed !== want.speed) begin
                        report_fault("speed", got.speed, want.speed);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_reading(in_ch.sample, want);
                readings_due.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_BITS-1:2])
                    REG_ALPHA:  alpha_q  = pwdata[ALPHA_BITS-1:0];
                    REG_SLOPE:  slope_q  = pwdata[SLOPE_BITS-1:0];
                    REG_OFFSET: offset_q = pwdata[OFFSET_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= readings_due.size();
    end

endmodule

[test/tb_wind_sensor_median_ema_calibrate.sv]
`timescale 1ns / 100ps
// top of the wind sensor filter testbench: clock, reset, sample and register stimulus, verdict
// depends on wsm_pkg, wsm_if, the block itself and wsm_result_checker
module tb_wind_sensor_median_ema_calibrate;
    import wsm_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 106;
    localparam int HOLD_AT_WORD  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;

    localparam logic [1:0]    REG_UNUSED = 2'd3;
    localparam logic [SB-1:0] SAMPLE_TOP = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int      n_sent = 0;
    int      pending;
    int      fail_count;
    int      cycle_count = 0;
    bit      sender_gaps = 1'b1;
    logic [SB-1:0] last_sample = '0;

    wsm_in_if  u_in_ch ();
    wsm_out_if u_out_ch ();

    wind_sensor_median_ema_calibrate u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_ch),
        .o_out   (u_out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wsm_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (u_in_ch),
        .out_ch       (u_out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly back to back, some short pauses, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] pick_reg16();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 16));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [23:0] pick_reg24();
        case ($urandom_range(0, 4))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // quiet phases pull the average down to zero now and then
    function logic [SB-1:0] pick_sample(input bit quiet);
        logic [SB-1:0] s;
        if (quiet && $urandom_range(0, 9) < 7) begin
            s = SB'($urandom_range(0, 3));
        end else begin
            case ($urandom_range(0, 9))
                0:       s = '0;
                1:       s = SAMPLE_TOP;
                2:       s = SB'($urandom_range(0, 3));
                3:       s = last_sample;
                default: s = SB'($urandom_range(0, int'(SAMPLE_TOP)));
            endcase
        end
        last_sample = s;
        return s;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // leave the bus idle before the next transfer
        @(negedge i_clk);
    endtask

    task automatic set_filter(input logic [15:0] alpha, input logic [15:0] slope,
                              input logic [23:0] offset, input bit noisy);
        logic [31:0] junk;
        junk = noisy ? $urandom() : 32'd0;
        apb_write(REG_ALPHA,  {junk[31:16], alpha});
        apb_write(REG_SLOPE,  {junk[31:16], slope});
        apb_write(REG_OFFSET, {junk[31:24], offset});
    endtask

    task automatic send_word(input logic [SB-1:0] x);
        int gap;
        u_in_ch.valid  <= 1'b1;
        u_in_ch.sample <= x;
        do @(posedge i_clk); while (!u_in_ch.ready);
        n_sent++;
        @(negedge i_clk);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            u_in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        u_in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // receiver: runs of ready, random stalls, one long hold-off to back the block up
    initial begin : receiver
        int stall_left;
        int run_left;
        bit long_hold_done;
        stall_left     = 0;
        run_left       = 0;
        long_hold_done = 1'b0;
        u_out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && n_sent >= HOLD_AT_WORD) begin
                long_hold_done = 1'b1;
                stall_left     = HOLD_CYCLES;
                run_left       = 0;
            end
            if (stall_left > 0) begin
                u_out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                u_out_ch.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(0, 12);
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : stimulus
        bit quiet;
        u_in_ch.valid  <= 1'b0;
        u_in_ch.sample <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_rst_n        <= 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: zeros in the window at start, zero reading, top of range
        send_word('0);
        send_word(SAMPLE_TOP);
        send_word(SAMPLE_TOP);
        send_word(SAMPLE_TOP);
        send_word(SB'(1));
        send_word(SB'(2048));
        send_word('0);
        send_word('0);
        send_word('0);
        wait_idle();

        // full alpha, largest slope and intercept: speed saturates, then drops to zero
        set_filter(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
        send_word(SAMPLE_TOP);
        send_word(SAMPLE_TOP);
        send_word(SB'(1));
        send_word('0);
        send_word('0);
        send_word('0);
        wait_idle();

        // alpha zero holds the average; a write past the register list goes nowhere
        set_filter(16'h0000, 16'd1, 24'h000000, 1'b0);
        apb_write(REG_UNUSED, '1);
        send_word(SAMPLE_TOP);
        send_word('0);
        send_word('0);
        send_word(SB'(2047));
        wait_idle();

        set_filter(16'h8000, 16'h0000, 24'h000000, 1'b0);
        send_word(SB'(3));
        send_word(SB'(3));
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            quiet       = (ph % 4 == 1);
            if (ph == RANDOM_PHASES - 1) begin
                set_filter(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
            end else begin
                set_filter(pick_reg16(), pick_reg16(), pick_reg24(), 1'b1);
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_word(pick_sample(quiet));
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
